>>> src/rect_and_disc_span_rasterizer_core_assert.svh
// Assertion macros for the span rasterizer core.
`ifndef RECT_AND_DISC_SPAN_RASTERIZER_CORE_ASSERT_SVH
`define RECT_AND_DISC_SPAN_RASTERIZER_CORE_ASSERT_SVH

// Clocked property, disabled while in reset.
`define RDSR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition that must never hold.
`define RDSR_NEVER(lbl, cond, msg) \
    `RDSR_ASSERT(lbl, !(cond), msg)

`endif

>>> src/rdsr_pkg.sv
// ----------------------------------------------------------------------------
// rdsr_pkg
// Shared constants and types of the rectangle and disc span rasterizer.
// ----------------------------------------------------------------------------
package rdsr_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 64;
    localparam int COL_W        = $clog2(FRAME_WIDTH + 1);
    localparam int ROW_W        = $clog2(FRAME_HEIGHT + 1);
    localparam int SQ_STEPS     = 12;

    localparam logic REQ_RECT = 1'b0;
    localparam logic REQ_DISC = 1'b1;

    // One row to rasterize, as issued by the row generator.
    typedef struct packed {
        logic              is_disc;
        logic              empty;
        logic              last;
        logic [ROW_W-1:0]  y;
        logic [COL_W-1:0]  x0;
        logic [COL_W-1:0]  x1;
        logic signed [12:0] cx;
        logic signed [12:0] cy;
        logic [11:0]       r;
        logic [7:0]        red;
        logic [7:0]        green;
        logic [7:0]        blue;
    } row_tok_t;

    typedef struct packed {
        logic [5:0] row;
        logic [5:0] first;
        logic [5:0] final_col;
        logic       valid;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } span_out_t;

endpackage

>>> src/rdsr_row_pipe.sv
// ----------------------------------------------------------------------------
// rdsr_row_pipe
// Row pipeline: dy, dy squared, remaining radius budget, 12-stage integer
// square root, then span edges clipped to the bounding box.
// ----------------------------------------------------------------------------
module rdsr_row_pipe (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  rdsr_pkg::row_tok_t   in_tok,
    output logic                 out_valid,
    output rdsr_pkg::span_out_t  out_span
);

    localparam int NS = rdsr_pkg::SQ_STEPS;

    // stage 1
    logic                 v1_reg;
    rdsr_pkg::row_tok_t   t1_reg;
    logic signed [14:0]   dy1_reg;
    logic [23:0]          r2_1_reg;
    // stage 2
    logic                 v2_reg;
    rdsr_pkg::row_tok_t   t2_reg;
    logic [24:0]          dy2_2_reg;
    logic [23:0]          r2_2_reg;
    // stage 3
    logic                 v3_reg;
    rdsr_pkg::row_tok_t   t3_reg;
    logic                 neg3_reg;
    logic [23:0]          rem3_reg;
    // square root stages
    logic                 sq_v_reg   [NS];
    rdsr_pkg::row_tok_t   sq_tok_reg [NS];
    logic                 sq_neg_reg [NS];
    logic [25:0]          sq_x_reg   [NS];
    logic [25:0]          sq_res_reg [NS];
    // output
    logic                 out_valid_reg;
    rdsr_pkg::span_out_t  out_reg;

    logic signed [14:0]   dy_c;
    logic [23:0]          r2_c;
    logic [13:0]          dmag_c;
    logic [27:0]          dsq_c;
    logic signed [25:0]   diff_c;
    logic [25:0]          sq_x_in   [NS];
    logic [25:0]          sq_res_in [NS];
    logic [25:0]          sq_sum_c  [NS];
    logic [25:0]          sq_x_next [NS];
    logic [25:0]          sq_res_next [NS];
    rdsr_pkg::span_out_t  out_next;

    always_comb begin
        dy_c   = 15'(signed'({1'b0, in_tok.y, 4'b1000})) - 15'(in_tok.cy);
        r2_c   = {12'b0, in_tok.r} * {12'b0, in_tok.r};
        dmag_c = dy1_reg[14] ? 14'(-dy1_reg) : 14'(dy1_reg);
        dsq_c  = {14'b0, dmag_c} * {14'b0, dmag_c};
        diff_c = signed'({2'b0, r2_2_reg}) - signed'({1'b0, dy2_2_reg});
    end

    // digit-by-digit square root, one result bit per stage
    always_comb begin
        sq_x_in[0]   = {2'b0, rem3_reg};
        sq_res_in[0] = '0;
        for (int k = 1; k < NS; k++) begin
            sq_x_in[k]   = sq_x_reg[k-1];
            sq_res_in[k] = sq_res_reg[k-1];
        end
        for (int k = 0; k < NS; k++) begin
            sq_sum_c[k] = sq_res_in[k] + (26'(1) << (22 - 2 * k));
            if (sq_x_in[k] >= sq_sum_c[k]) begin
                sq_x_next[k]   = sq_x_in[k] - sq_sum_c[k];
                sq_res_next[k] = (sq_res_in[k] >> 1) + (26'(1) << (22 - 2 * k));
            end else begin
                sq_x_next[k]   = sq_x_in[k];
                sq_res_next[k] = sq_res_in[k] >> 1;
            end
        end
    end

    // span edges: |16x+8-cx| <= root
    rdsr_pkg::row_tok_t  ft;
    logic signed [15:0]  root_c, cx_c, lo_c, hi_c, fa_c, fb_c, bx0_c, bx1_c, f1_c, f2_c;
    logic                hit_c;

    always_comb begin
        ft     = sq_tok_reg[NS-1];
        root_c = signed'({4'b0, sq_res_reg[NS-1][11:0]});
        cx_c   = 16'(ft.cx);
        lo_c   = cx_c - root_c - 16'sd8;
        hi_c   = cx_c + root_c - 16'sd8;
        fa_c   = (lo_c + 16'sd15) >>> 4;
        fb_c   = hi_c >>> 4;
        bx0_c  = signed'(16'(ft.x0));
        bx1_c  = signed'(16'(ft.x1));
        f1_c   = (fa_c > bx0_c) ? fa_c : bx0_c;
        f2_c   = (fb_c < bx1_c) ? fb_c : bx1_c;
        hit_c  = !sq_neg_reg[NS-1] && (f1_c <= f2_c);

        out_next.red       = ft.red;
        out_next.green     = ft.green;
        out_next.blue      = ft.blue;
        out_next.last      = ft.last;
        out_next.row       = 6'(ft.y);
        out_next.first     = 6'(ft.x0);
        out_next.final_col = 6'(ft.x1);
        out_next.valid     = 1'b1;
        if (ft.empty) begin
            out_next.row       = '0;
            out_next.first     = '0;
            out_next.final_col = '0;
            out_next.valid     = 1'b0;
        end else if (ft.is_disc) begin
            if (hit_c) begin
                out_next.first     = 6'(f1_c);
                out_next.final_col = 6'(f2_c);
            end else begin
                out_next.first     = '0;
                out_next.final_col = '0;
                out_next.valid     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NS; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            sq_v_reg[0]   <= v3_reg;
            for (int k = 1; k < NS; k++) begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
            out_valid_reg <= sq_v_reg[NS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg        <= in_tok;
            dy1_reg       <= dy_c;
            r2_1_reg      <= r2_c;
            t2_reg        <= t1_reg;
            dy2_2_reg     <= dsq_c[24:0];
            r2_2_reg      <= r2_1_reg;
            t3_reg        <= t2_reg;
            neg3_reg      <= diff_c[25];
            rem3_reg      <= diff_c[23:0];
            sq_tok_reg[0] <= t3_reg;
            sq_neg_reg[0] <= neg3_reg;
            for (int k = 1; k < NS; k++) begin
                sq_tok_reg[k] <= sq_tok_reg[k-1];
                sq_neg_reg[k] <= sq_neg_reg[k-1];
            end
            for (int k = 0; k < NS; k++) begin
                sq_x_reg[k]   <= sq_x_next[k];
                sq_res_reg[k] <= sq_res_next[k];
            end
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_span  = out_reg;

endmodule

>>> src/rect_and_disc_span_rasterizer_core.sv
// A command is registered in the row generator; each of its rows then passes through
// the row pipeline to m_*. The generator issues one row per cycle while no span waits,
// one per clipped row (one empty row when the command is off screen).
// The generator and the 16-stage row pipeline (12 of them square root)
// advance together and freeze while an output span waits.
// Reset: synchronous, active low; clears the generator and all valid bits.
// ----------------------------------------------------------------------------
// rect_and_disc_span_rasterizer_core
// Clips a rectangle or disc command to the frame and emits one span per row.
// ----------------------------------------------------------------------------
`include "rect_and_disc_span_rasterizer_core_assert.svh"

module rect_and_disc_span_rasterizer_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_req_type,
    input  logic signed [7:0]  s_rect_left,
    input  logic signed [7:0]  s_rect_top,
    input  logic [7:0]         s_rect_width,
    input  logic [7:0]         s_rect_height,
    input  logic signed [12:0] s_centre_x,
    input  logic signed [12:0] s_centre_y,
    input  logic [11:0]        s_disc_radius,
    input  logic [7:0]         s_colour_red,
    input  logic [7:0]         s_colour_green,
    input  logic [7:0]         s_colour_blue,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_span_row,
    output logic [5:0]         m_span_first,
    output logic [5:0]         m_span_final,
    output logic               m_span_valid,
    output logic [7:0]         m_out_red,
    output logic [7:0]         m_out_green,
    output logic [7:0]         m_out_blue,
    output logic               m_last_span
);

    localparam logic signed [15:0] FW = 16'(rdsr_pkg::FRAME_WIDTH);
    localparam logic signed [15:0] FH = 16'(rdsr_pkg::FRAME_HEIGHT);

    logic                               en;
    logic                               busy_reg;
    rdsr_pkg::row_tok_t                 cmd_reg;
    logic [rdsr_pkg::ROW_W-1:0]         y_reg;
    logic [rdsr_pkg::ROW_W-1:0]         y1_reg;
    rdsr_pkg::row_tok_t                 tok;
    logic                               pipe_valid;
    rdsr_pkg::span_out_t                pipe_span;
    logic                               accept;

    // bounding box of the incoming command
    logic signed [15:0] rl, rt, rw, rh, rxe, rye, cx, cy, rr;
    logic signed [15:0] bx0, bx1, by0, by1, dlo_x, dlo_y, dhi_x, dhi_y;
    logic               empty_c;

    always_comb begin
        rl = 16'(s_rect_left);
        rt = 16'(s_rect_top);
        rw = signed'(16'(s_rect_width));
        rh = signed'(16'(s_rect_height));
        cx = 16'(s_centre_x);
        cy = 16'(s_centre_y);
        rr = signed'(16'(s_disc_radius));
        rxe   = ((rl + rw) > FW) ? FW : (rl + rw);
        rye   = ((rt + rh) > FH) ? FH : (rt + rh);
        dlo_x = (cx - rr) >>> 4;
        dlo_y = (cy - rr) >>> 4;
        dhi_x = (cx + rr + 16'sd15) >>> 4;
        dhi_y = (cy + rr + 16'sd15) >>> 4;
        if (s_req_type == rdsr_pkg::REQ_DISC) begin
            bx0 = (dlo_x < 0) ? 16'sd0 : dlo_x;
            by0 = (dlo_y < 0) ? 16'sd0 : dlo_y;
            bx1 = (dhi_x > FW - 16'sd1) ? FW - 16'sd1 : dhi_x;
            by1 = (dhi_y > FH - 16'sd1) ? FH - 16'sd1 : dhi_y;
        end else begin
            bx0 = (rl < 0) ? 16'sd0 : rl;
            by0 = (rt < 0) ? 16'sd0 : rt;
            bx1 = rxe - 16'sd1;
            by1 = rye - 16'sd1;
        end
        empty_c = (bx0 > bx1) || (by0 > by1);
    end

    always_comb begin
        tok      = cmd_reg;
        tok.y    = y_reg;
        tok.last = cmd_reg.empty || (y_reg == y1_reg);
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = !busy_reg || (en && tok.last);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (accept) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && en && tok.last) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg.is_disc <= (s_req_type == rdsr_pkg::REQ_DISC);
            cmd_reg.empty   <= empty_c;
            cmd_reg.last    <= 1'b0;
            cmd_reg.y       <= '0;
            cmd_reg.x0      <= rdsr_pkg::COL_W'(bx0);
            cmd_reg.x1      <= rdsr_pkg::COL_W'(bx1);
            cmd_reg.cx      <= s_centre_x;
            cmd_reg.cy      <= s_centre_y;
            cmd_reg.r       <= s_disc_radius;
            cmd_reg.red     <= s_colour_red;
            cmd_reg.green   <= s_colour_green;
            cmd_reg.blue    <= s_colour_blue;
            y_reg           <= empty_c ? '0 : rdsr_pkg::ROW_W'(by0);
            y1_reg          <= rdsr_pkg::ROW_W'(by1);
        end else if (busy_reg && en && !tok.last) begin
            y_reg <= y_reg + 1'b1;
        end
    end

    rdsr_row_pipe u_row_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (busy_reg),
        .in_tok    (tok),
        .out_valid (pipe_valid),
        .out_span  (pipe_span)
    );

    assign m_valid      = pipe_valid;
    assign m_span_row   = pipe_span.row;
    assign m_span_first = pipe_span.first;
    assign m_span_final = pipe_span.final_col;
    assign m_span_valid = pipe_span.valid;
    assign m_out_red    = pipe_span.red;
    assign m_out_green  = pipe_span.green;
    assign m_out_blue   = pipe_span.blue;
    assign m_last_span  = pipe_span.last;

    `RDSR_ASSERT(a_span_order, m_valid && m_span_valid |-> m_span_first <= m_span_final,
        "span first column beyond last column")
    `RDSR_ASSERT(a_empty_zero, m_valid && !m_span_valid |-> m_span_first == 6'd0 &&
        m_span_final == 6'd0, "invalid span with nonzero columns")
    `RDSR_ASSERT(a_accept_busy, accept |=> busy_reg, "command accepted but generator idle")
    `RDSR_NEVER(a_row_overrun, busy_reg && !cmd_reg.empty && (y_reg > y1_reg),
        "row generator ran past bounding box")

endmodule
